/* design/led_strip_frame_generator_defines.svh */
// ----------------------------------------------------------------------------
// LED strip frame generator assertion macros
// Shared property wrappers for the checker of the frame generator.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_GENERATOR_DEFINES_SVH
`define LED_STRIP_FRAME_GENERATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LSFG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LSFG_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LSFG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lsfg_pkg.sv */
// ----------------------------------------------------------------------------
// LED strip frame generator package
// Transaction types, codes, constants and the sequencer microprogram.
// ----------------------------------------------------------------------------
package lsfg_pkg;

  localparam int PIXEL_COUNT_DEFAULT = 8;
  localparam int START_BYTES         = 4;
  localparam int BRIGHT_W            = 5;

  localparam logic [7:0]          PIXEL_HEADER = 8'b1110_0000;
  localparam logic [7:0]          ZERO_BYTE    = 8'h00;
  localparam logic [7:0]          END_BYTE     = 8'hFF;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'h1F;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SHOW  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  // One stored pixel: red[28:21] green[20:13] blue[12:5] brightness[4:0]
  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [BRIGHT_W-1:0] bright;
  } pixel_t;

  // Byte source selected by a microinstruction
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_HEADER,
    SRC_BLUE,
    SRC_GREEN,
    SRC_RED,
    SRC_ONES
  } src_e;

  // Loop condition tested by a microinstruction
  typedef enum logic [1:0] {
    COND_NONE,
    COND_START,
    COND_PIXEL,
    COND_END
  } cond_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_START = 3'd0;
  localparam upc_t UPC_HEAD  = 3'd1;
  localparam upc_t UPC_BLUE  = 3'd2;
  localparam upc_t UPC_GREEN = 3'd3;
  localparam upc_t UPC_RED   = 3'd4;
  localparam upc_t UPC_END   = 3'd5;

  typedef struct packed {
    src_e  src;
    logic  cnt_inc;
    cond_e cond;
    upc_t  taken;
    upc_t  fall;
    logic  halt;
  } uword_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    logic emit;
    src_e src;
    logic last;
  } ctrl_t;

  // Microprogram: one control word per step
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      UPC_START: w = '{SRC_ZERO,   1'b1, COND_START, UPC_HEAD,  UPC_START, 1'b0};
      UPC_HEAD:  w = '{SRC_HEADER, 1'b0, COND_NONE,  UPC_BLUE,  UPC_BLUE,  1'b0};
      UPC_BLUE:  w = '{SRC_BLUE,   1'b0, COND_NONE,  UPC_GREEN, UPC_GREEN, 1'b0};
      UPC_GREEN: w = '{SRC_GREEN,  1'b0, COND_NONE,  UPC_RED,   UPC_RED,   1'b0};
      UPC_RED:   w = '{SRC_RED,    1'b1, COND_PIXEL, UPC_END,   UPC_HEAD,  1'b0};
      UPC_END:   w = '{SRC_ONES,   1'b1, COND_END,   UPC_START, UPC_END,   1'b1};
      default:   w = '{SRC_ONES,   1'b0, COND_NONE,  UPC_START, UPC_START, 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* design/led_strip_frame_generator.sv */
// ----------------------------------------------------------------------------
// LED strip frame generator
// Pixel store and frame byte stream for a two-wire addressable LED strip.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   A write command stores red, green, blue and the current brightness at
//   pixel_index when taken; indexes at or beyond PIXEL_COUNT are dropped.
//   Neither writes nor unknown operations produce results.
//   A show command streams 4 + 4*PIXEL_COUNT + (PIXEL_COUNT+1)/2 bytes, one
//   per cycle (40 bytes at eight pixels), set by the microprogram stepping
//   one control word per byte. busy stays high through the final step.
//   A clear command blackens every pixel at the current brightness in the
//   cycle it is taken and then streams the frame as a show does.
//   Each byte appears on result with result_valid high for exactly one cycle,
//   in the cycle after the step that selects it; the final end byte carries
//   last_byte. The receiver cannot stall the stream.
//   The brightness register is written via cfg_valid/cfg_ready (always ready);
//   the user must write it only while no frame is in flight (unchecked).
//   Reset clears the store to zeros, sets brightness to 31 and idles.
// ----------------------------------------------------------------------------
module led_strip_frame_generator #(
  parameter int PIXEL_COUNT = lsfg_pkg::PIXEL_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lsfg_pkg::cmd_t                cmd,
  output logic                          result_valid,
  output lsfg_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsfg_pkg::BRIGHT_W-1:0] cfg_data
);

  localparam int PIX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  logic                          take;
  logic                          launch;
  logic                          clear;
  logic                          wr_en;
  logic [lsfg_pkg::BRIGHT_W-1:0] bright;
  lsfg_pkg::ctrl_t               ctrl;
  logic [PIX_W-1:0]              pix;

  // Decode the accepted command
  assign take   = start && !busy;
  assign clear  = take && (cmd.operation == lsfg_pkg::OP_CLEAR);
  assign launch = take && ((cmd.operation == lsfg_pkg::OP_SHOW) ||
                           (cmd.operation == lsfg_pkg::OP_CLEAR));
  assign wr_en  = take && (cmd.operation == lsfg_pkg::OP_WRITE) &&
                  ({1'b0, cmd.pixel_index} < 5'(PIXEL_COUNT));

  // Brightness register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright <= lsfg_pkg::BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bright <= cfg_data;
    end
  end

  lsfg_sequencer #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .PIX_W       (PIX_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .busy   (busy),
    .ctrl   (ctrl),
    .pix    (pix)
  );

  lsfg_datapath #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .PIX_W       (PIX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_idx       (cmd.pixel_index[PIX_W-1:0]),
    .cmd          (cmd),
    .clear        (clear),
    .bright       (bright),
    .ctrl         (ctrl),
    .pix          (pix),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* design/lsfg_sequencer.sv */
// ----------------------------------------------------------------------------
// LED strip frame sequencer
// Step counter, loop counter and microprogram lookup for frame emission.
// ----------------------------------------------------------------------------
module lsfg_sequencer #(
  parameter int PIXEL_COUNT = lsfg_pkg::PIXEL_COUNT_DEFAULT,
  parameter int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 launch,
  output logic                 busy,
  output lsfg_pkg::ctrl_t      ctrl,
  output logic [PIX_W-1:0]     pix
);

  localparam int MAX_LOOP  = (PIXEL_COUNT > lsfg_pkg::START_BYTES) ?
                             PIXEL_COUNT : lsfg_pkg::START_BYTES;
  localparam int CNT_W     = $clog2(MAX_LOOP);
  localparam int END_COUNT = (PIXEL_COUNT + 1) / 2;

  logic                  run;
  lsfg_pkg::upc_t        pc;
  lsfg_pkg::upc_t        pc_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      limit;
  logic                  hit;
  lsfg_pkg::uword_t      uw;

  // Fetch the control word of the current step
  assign uw = lsfg_pkg::ucode(pc);

  // Select the loop bound and test it
  always_comb begin
    case (uw.cond)
      lsfg_pkg::COND_START: limit = CNT_W'(lsfg_pkg::START_BYTES - 1);
      lsfg_pkg::COND_PIXEL: limit = CNT_W'(PIXEL_COUNT - 1);
      lsfg_pkg::COND_END:   limit = CNT_W'(END_COUNT - 1);
      default:              limit = '0;
    endcase
    hit = (uw.cond != lsfg_pkg::COND_NONE) && (cnt == limit);
  end

  // Branch and advance the loop counter
  always_comb begin
    pc_next  = hit ? uw.taken : uw.fall;
    if (hit) begin
      cnt_next = '0;
    end else if (uw.cnt_inc) begin
      cnt_next = cnt + 1'b1;
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pc  <= lsfg_pkg::UPC_START;
      cnt <= '0;
    end else if (launch) begin
      run <= 1'b1;
      pc  <= lsfg_pkg::UPC_START;
      cnt <= '0;
    end else if (run) begin
      pc  <= pc_next;
      cnt <= cnt_next;
      if (hit && uw.halt) begin
        run <= 1'b0;
      end
    end
  end

  // Drive the datapath
  assign busy      = run;
  assign ctrl.emit = run;
  assign ctrl.src  = uw.src;
  assign ctrl.last = hit && uw.halt;
  assign pix       = cnt[PIX_W-1:0];

endmodule

/* design/lsfg_datapath.sv */
// ----------------------------------------------------------------------------
// LED strip frame datapath
// Pixel store, byte selection and the registered result stage.
// ----------------------------------------------------------------------------
module lsfg_datapath #(
  parameter int PIXEL_COUNT = lsfg_pkg::PIXEL_COUNT_DEFAULT,
  parameter int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [PIX_W-1:0]              wr_idx,
  input  lsfg_pkg::cmd_t                cmd,
  input  logic                          clear,
  input  logic [lsfg_pkg::BRIGHT_W-1:0] bright,
  input  lsfg_pkg::ctrl_t               ctrl,
  input  logic [PIX_W-1:0]              pix,
  output logic                          result_valid,
  output lsfg_pkg::result_t             result
);

  lsfg_pkg::pixel_t store [PIXEL_COUNT];
  lsfg_pkg::pixel_t cur;
  logic [7:0]       byte_sel;

  // Update the pixel store: reset, clear all, or write one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIXEL_COUNT; i++) begin
        store[i] <= '0;
      end
    end else if (clear) begin
      for (int i = 0; i < PIXEL_COUNT; i++) begin
        store[i] <= '{8'h00, 8'h00, 8'h00, bright};
      end
    end else if (wr_en) begin
      store[wr_idx] <= '{cmd.red, cmd.green, cmd.blue, bright};
    end
  end

  // Pick the byte for the current step
  always_comb begin
    cur = store[pix];
    case (ctrl.src)
      lsfg_pkg::SRC_ZERO:   byte_sel = lsfg_pkg::ZERO_BYTE;
      lsfg_pkg::SRC_HEADER: byte_sel = lsfg_pkg::PIXEL_HEADER | {3'b000, cur.bright};
      lsfg_pkg::SRC_BLUE:   byte_sel = cur.blue;
      lsfg_pkg::SRC_GREEN:  byte_sel = cur.green;
      lsfg_pkg::SRC_RED:    byte_sel = cur.red;
      default:              byte_sel = lsfg_pkg::END_BYTE;
    endcase
  end

  // Register the result valid flag from the emit control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    result.frame_byte <= byte_sel;
    result.last_byte  <= ctrl.last;
  end

endmodule

/* design/lsfg_checker.sv */
// ----------------------------------------------------------------------------
// LED strip frame generator checker
// Port-level assertions on frame framing and busy behavior.
// ----------------------------------------------------------------------------
`include "led_strip_frame_generator_defines.svh"

module lsfg_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input lsfg_pkg::cmd_t    cmd,
  input logic              result_valid,
  input lsfg_pkg::result_t result
);

  // The frame ends with an end byte
  `LSFG_ASSERT_IMPLY(a_last_is_end, clk, rst, result_valid && result.last_byte, result.frame_byte == lsfg_pkg::END_BYTE, "last byte is not an end byte")

  // A show or clear transaction starts a frame
  `LSFG_ASSERT_NEXT(a_launch_busy, clk, rst, start && !busy && (cmd.operation == lsfg_pkg::OP_SHOW || cmd.operation == lsfg_pkg::OP_CLEAR), busy, "frame did not start")

  // Busy drops exactly as the last byte is shown
  `LSFG_ASSERT_IMPLY(a_end_on_last, clk, rst, $fell(busy) && !$past(rst), result_valid && result.last_byte, "frame ended without last byte")

  // No bytes appear between frames
  `LSFG_ASSERT(a_quiet_idle, clk, rst, !(result_valid && !busy && !$past(busy) && !$past(rst)), "byte outside a frame")

endmodule

bind led_strip_frame_generator lsfg_checker u_lsfg_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
